// File: rtl/utrx_pkg.sv
// Shared constants, request and status codes, and inter-module structs for the UART transceiver.
package utrx_pkg;

  // Receive ring FIFO geometry; one slot stays free, so it holds FIFO_DEPTH-1 bytes
  localparam int unsigned FIFO_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

  // Fixed field widths
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 6;
  localparam int unsigned BIT_IDX_W   = 4;
  localparam int unsigned IN_DATA_W   = 16;
  localparam int unsigned OUT_DATA_W  = 16;
  localparam int unsigned USER_W      = 2;
  localparam int unsigned CFG_IDX_W   = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT     = 1'b1;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_READ  = 2'd1,
    REQ_WRITE = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_NOCFG = 2'd2,
    STAT_BUSY  = 2'd3
  } status_e;

  // Byte handed from the receiver to the FIFO
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } push_t;

  // Host-side FIFO controls for one transaction
  typedef struct packed {
    logic pop;
    logic clear;
  } fifo_req_t;

  // FIFO view: empty and head byte before the transaction, count and flag after it
  typedef struct packed {
    logic               empty;
    logic [BYTE_W-1:0]  rd_data;
    logic [COUNT_W-1:0] count;
    logic               overflow;
  } fifo_rsp_t;

endpackage

// File: rtl/uart_transceiver_with_rx_fifo_unit.sv
// Top level of the UART 8N1 transceiver with receive FIFO, stream ports and output skid.
//
// Usage:
//   Each input transaction is one request: a baud tick (carrying the sampled
//   receive line), a FIFO read, a transmit write or a FIFO/overflow clear,
//   selected by s_axis_tuser_i. Every request yields exactly one result with
//   the transmit line level, the popped byte, a status code, the FIFO count
//   and the sticky overflow flag.
//   The result is registered and driven on m_axis; a stalled one may wait in the skid register.
//   Throughput: one request per clock cycle while s_axis_tready_o is high,
//   set by the single pass through the receiver, transmitter and FIFO
//   pointer logic; the FIFO store is a RAM whose head entry is prefetched at
//   the next read pointer, so a read completes in the same pass.
//   Stalls: when m_axis_tready_i is low a second result is parked in a skid
//   register; s_axis_tready_o drops only while that register is occupied.
//   Reset: FIFO empty, overflow clear, both line machines idle, bit_period and
//   invert_logic zero (transmit refused until a bit period is written). The
//   FIFO store needs no clearing pass. Write configuration only while idle.
module uart_transceiver_with_rx_fifo_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [utrx_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [utrx_pkg::PERIOD_W-1:0]      cfg_data_i,
  // Request stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [utrx_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,  // rx_level, tx_byte, zero pad
  input  logic [utrx_pkg::USER_W-1:0]        s_axis_tuser_i,  // req_type
  // Result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [utrx_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,  // tx_level, read_data, fifo_count, overflow
  output logic [utrx_pkg::USER_W-1:0]        m_axis_tuser_o   // req_status
);
  import utrx_pkg::*;

  logic [PERIOD_W-1:0]   bit_period_q;
  logic                  invert_q;

  logic                  acc;
  req_e                  req;
  logic                  tick, rd_req, wr_req, clr_req;
  logic                  rx_level;
  logic [BYTE_W-1:0]     tx_byte;

  push_t                 push;
  fifo_req_t             fifo_req;
  fifo_rsp_t             fifo_rsp;
  logic                  tx_busy, tx_level;

  status_e               status;
  logic [BYTE_W-1:0]     read_data;
  logic [OUT_DATA_W-1:0] res_data;

  logic                  out_vld_q, skid_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q, skid_data_q;
  logic [USER_W-1:0]     out_user_q, skid_user_q;

  // Decode the accepted transaction
  assign acc      = s_axis_tvalid_i && s_axis_tready_o;
  assign req      = req_e'(s_axis_tuser_i);
  assign tick     = acc && (req == REQ_TICK);
  assign rd_req   = acc && (req == REQ_READ);
  assign wr_req   = acc && (req == REQ_WRITE);
  assign clr_req  = acc && (req == REQ_CLEAR);
  assign rx_level = s_axis_tdata_i[0];
  assign tx_byte  = s_axis_tdata_i[BYTE_W:1];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_period_q <= '0;
      invert_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BIT_PERIOD: bit_period_q <= cfg_data_i;
        CFG_INVERT:     invert_q     <= cfg_data_i[0];
      endcase
    end
  end

  utrx_rx u_rx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .rx_level_i   (rx_level),
    .bit_period_i (bit_period_q),
    .invert_i     (invert_q),
    .push_o       (push)
  );

  utrx_tx u_tx (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .write_i      (wr_req),
    .tx_byte_i    (tx_byte),
    .bit_period_i (bit_period_q),
    .invert_i     (invert_q),
    .busy_o       (tx_busy),
    .tx_level_o   (tx_level)
  );

  assign fifo_req.pop   = rd_req;
  assign fifo_req.clear = clr_req;

  utrx_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .req_i  (fifo_req),
    .rsp_o  (fifo_rsp)
  );

  // Build the result for this transaction
  always_comb begin
    status    = STAT_OK;
    read_data = '0;
    unique case (req)
      REQ_READ: begin
        if (fifo_rsp.empty) begin
          status = STAT_EMPTY;
        end else begin
          read_data = fifo_rsp.rd_data;
        end
      end
      REQ_WRITE: begin
        if (bit_period_q == '0) begin
          status = STAT_NOCFG;
        end else if (tx_busy) begin
          status = STAT_BUSY;
        end
      end
      REQ_TICK,
      REQ_CLEAR: status = STAT_OK;
    endcase
    res_data = {fifo_rsp.overflow, fifo_rsp.count, read_data, tx_level};
  end

  // Output register with one skid slot behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready_i) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= acc;
      end
    end else if (acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready_i) begin
      if (skid_vld_q) begin
        out_data_q <= skid_data_q;
        out_user_q <= skid_user_q;
      end else if (acc) begin
        out_data_q <= res_data;
        out_user_q <= USER_W'(status);
      end
    end else if (acc) begin
      skid_data_q <= res_data;
      skid_user_q <= USER_W'(status);
    end
  end

  assign s_axis_tready_o = !skid_vld_q;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // The skid slot only fills behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid slot valid with empty output register");

  // After an accepted transaction the output register always holds a valid result
  a_acc_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_vld_q)
    else $error("accepted transaction produced no result");

  // A stalled result is never lost
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready_i) |=> out_vld_q)
    else $error("stalled result dropped");

endmodule

// File: rtl/utrx_ram.sv
// Generic single-write, single-read RAM with registered read data (write-first).
module utrx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, new data wins on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/utrx_rx.sv
// UART 8N1 receiver: start detect, mid-bit sampling, byte push toward the FIFO.
module utrx_rx (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  input  logic                            rx_level_i,
  input  logic [utrx_pkg::PERIOD_W-1:0]   bit_period_i,
  input  logic                            invert_i,
  output utrx_pkg::push_t                 push_o
);
  import utrx_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [PERIOD_W-1:0]    cnt_q, cnt_d, cnt_inc;
  logic [BIT_IDX_W-1:0]   idx_q, idx_d;
  logic [BYTE_W-1:0]      shift_q, shift_d;
  logic                   bit_val;

  // Advance the receive state on tick transactions only
  always_comb begin
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    shift_d      = shift_q;
    push_o.valid = 1'b0;
    cnt_inc      = cnt_q + 1'b1;
    bit_val      = rx_level_i ^ invert_i;
    if (tick_i) begin
      unique case (phase_q)
        PH_IDLE: begin
          if (!bit_val && (bit_period_i != '0)) begin
            phase_d = PH_START;
            cnt_d   = '0;
            idx_d   = '0;
            shift_d = '0;
          end
        end
        PH_START: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= (bit_period_i >> 1)) begin
            phase_d = PH_DATA;
            cnt_d   = '0;
          end
        end
        PH_DATA: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= bit_period_i) begin
            cnt_d   = '0;
            shift_d = shift_q | (BYTE_W'(bit_val) << idx_q[2:0]);
            idx_d   = idx_q + 1'b1;
            if (idx_d >= BIT_IDX_W'(BYTE_W)) begin
              push_o.valid = 1'b1;
              phase_d      = PH_STOP;
            end
          end
        end
        PH_STOP: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= bit_period_i) begin
            phase_d = PH_IDLE;
            cnt_d   = '0;
            idx_d   = '0;
          end
        end
      endcase
    end
    push_o.data = shift_d;
  end

  // Hold receive state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

endmodule

// File: rtl/utrx_tx.sv
// UART 8N1 transmitter: frame sequencing and the transmit line level.
module utrx_tx (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            tick_i,
  input  logic                            write_i,
  input  logic [utrx_pkg::BYTE_W-1:0]     tx_byte_i,
  input  logic [utrx_pkg::PERIOD_W-1:0]   bit_period_i,
  input  logic                            invert_i,
  output logic                            busy_o,
  output logic                            tx_level_o
);
  import utrx_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic [PERIOD_W-1:0]    cnt_q, cnt_d, cnt_inc;
  logic [BIT_IDX_W-1:0]   idx_q, idx_d;
  logic [BYTE_W-1:0]      shift_q, shift_d;
  logic                   logical;

  assign busy_o = (phase_q != PH_IDLE);

  // Start a frame on an accepted write, step bit timing on ticks
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    shift_d = shift_q;
    cnt_inc = cnt_q + 1'b1;
    if (write_i) begin
      if ((bit_period_i != '0) && (phase_q == PH_IDLE)) begin
        phase_d = PH_START;
        cnt_d   = '0;
        idx_d   = '0;
        shift_d = tx_byte_i;
      end
    end else if (tick_i && (phase_q != PH_IDLE)) begin
      cnt_d = cnt_inc;
      if (cnt_inc >= bit_period_i) begin
        cnt_d = '0;
        unique case (phase_q)
          PH_START: begin
            phase_d = PH_DATA;
            idx_d   = '0;
          end
          PH_DATA: begin
            idx_d = idx_q + 1'b1;
            if (idx_d >= BIT_IDX_W'(BYTE_W)) begin
              phase_d = PH_STOP;
            end
          end
          PH_STOP: begin
            phase_d = PH_IDLE;
            idx_d   = '0;
          end
          PH_IDLE: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Drive the line from the state left by this transaction
  always_comb begin
    unique case (phase_d)
      PH_START: logical = 1'b0;
      PH_DATA:  logical = shift_d[idx_d[2:0]];
      PH_IDLE,
      PH_STOP:  logical = 1'b1;
    endcase
    tx_level_o = logical ^ invert_i;
  end

  // Hold transmit state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      shift_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      shift_q <= shift_d;
    end
  end

  // Data phase never runs past the last data bit
  a_tx_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (idx_q < BIT_IDX_W'(BYTE_W)))
    else $error("tx bit index out of range in data phase");

endmodule

// File: rtl/utrx_fifo.sv
// Receive ring FIFO: pointers, overflow flag, and the byte store.
module utrx_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  utrx_pkg::push_t       push_i,
  input  utrx_pkg::fifo_req_t   req_i,
  output utrx_pkg::fifo_rsp_t   rsp_o
);
  import utrx_pkg::*;

  localparam int unsigned CNT_W = PTR_W + 1;

  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d, wp_inc;
  logic             ovf_q, ovf_d;
  logic             empty, full, wr_en;
  logic [CNT_W-1:0] used;
  logic [BYTE_W-1:0] rdata;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  assign wp_inc = ptr_inc(wp_q);
  assign empty  = (rp_q == wp_q);
  assign full   = (wp_inc == rp_q);
  assign wr_en  = push_i.valid && !full;

  // Update pointers and overflow for this transaction
  always_comb begin
    rp_d  = rp_q;
    wp_d  = wp_q;
    ovf_d = ovf_q;
    if (req_i.clear) begin
      rp_d  = '0;
      wp_d  = '0;
      ovf_d = 1'b0;
    end else if (req_i.pop && !empty) begin
      rp_d = ptr_inc(rp_q);
    end else if (push_i.valid) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        wp_d = wp_inc;
      end
    end
  end

  // Occupancy after this transaction
  always_comb begin
    if (wp_d >= rp_d) begin
      used = {1'b0, wp_d} - {1'b0, rp_d};
    end else begin
      used = {1'b0, wp_d} + CNT_W'(FIFO_DEPTH) - {1'b0, rp_d};
    end
  end

  // Prefetch the head entry for the next transaction
  utrx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wp_q),
    .wdata_i (push_i.data),
    .raddr_i (rp_d),
    .rdata_o (rdata)
  );

  assign rsp_o.empty    = empty;
  assign rsp_o.rd_data  = rdata;
  assign rsp_o.count    = COUNT_W'(used);
  assign rsp_o.overflow = ovf_d;

  // Hold pointers and flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q  <= '0;
      wp_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      rp_q  <= rp_d;
      wp_q  <= wp_d;
      ovf_q <= ovf_d;
    end
  end

  // A byte dropped on a full FIFO must leave the flag set
  a_ovf_on_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.valid && full && !req_i.clear) |=> ovf_q)
    else $error("dropped byte did not set overflow");

  // Pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rp_q <= PTR_W'(FIFO_DEPTH - 1)) && (wp_q <= PTR_W'(FIFO_DEPTH - 1)))
    else $error("fifo pointer outside ring");

endmodule
